// ===== src/assert_macros.svh =====
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== src/tpgt_pkg.sv =====
package tpgt_pkg;

	localparam int TITLE_SLOTS = 16;
	localparam int COUNT_BITS = 32;
	localparam int TITLE_BITS = 4;
	localparam int MODE_BITS = 4;
	localparam int OUT_COUNT_BITS = 32;
	localparam int MAP_IW = $clog2(TITLE_SLOTS);

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [TITLE_SLOTS-1:0] map_t;
	typedef logic [TITLE_BITS-1:0] title_t;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_SAMPLE = 3'd1,
		CMD_TOGGLE = 3'd2,
		CMD_STOP = 3'd3,
		CMD_MODE_RESET = 3'd4,
		CMD_ADAPTIVE = 3'd5,
		CMD_CLEAR_TITLE = 3'd6,
		CMD_CLEAR_ALL = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_ALWAYS = 2'd0,
		MODE_UNTIL_CUED = 2'd1,
		MODE_UNTIL_HOTKEY = 2'd2,
		MODE_CUSTOM = 2'd3
	} mode_t;

	// One input word, unpacked from the stream.
	typedef struct packed {
		cmd_t cmd;
		logic is_ticker_layer;
		logic title_given;
		title_t title_number;
		logic title_cued_flag;
		logic signed [MODE_BITS-1:0] mode_request;
		logic adaptive_request;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [OUT_COUNT_BITS-1:0] elapsed_count;
		logic paused_now;
	} result_t;

	// Channel state, without the adaptive-pause map.
	typedef struct packed {
		cnt_t cnt;
		mode_t mode;
		logic started;
		logic held;
		logic manual;
		logic cue_open;
		logic hot_open;
		logic cued_last;
		title_t title;
		logic present;
	} chan_t;

	localparam chan_t CHAN_RESET = '{
		cnt: '0,
		mode: MODE_ALWAYS,
		started: 1'b0,
		held: 1'b1,
		manual: 1'b0,
		cue_open: 1'b1,
		hot_open: 1'b1,
		cued_last: 1'b0,
		title: '0,
		present: 1'b0
	};

	// Adaptive bit of a title; titles beyond the map read as not paused.
	function automatic logic map_read(map_t m, title_t t);
		logic hit;
		hit = (32'(t) < TITLE_SLOTS);
		return hit ? m[MAP_IW'(t)] : 1'b0;
	endfunction

	function automatic logic title_in_map(title_t t);
		return (32'(t) < TITLE_SLOTS);
	endfunction

	// Effective pause from hold, mode gate and adaptive bit.
	function automatic logic eff_paused(chan_t s, map_t m);
		logic gate;
		gate = 1'b0;
		if (s.mode == MODE_UNTIL_CUED)
			gate = !s.cue_open;
		else if (s.mode == MODE_UNTIL_HOTKEY)
			gate = !s.hot_open;
		return s.manual | gate | (s.present & map_read(m, s.title));
	endfunction

	// Restart the channel at count zero with the gates of a mode.
	function automatic chan_t start_mode(chan_t s, mode_t mode, map_t m);
		chan_t r;
		r = s;
		r.cnt = '0;
		r.mode = mode;
		r.manual = 1'b0;
		r.cue_open = (mode != MODE_UNTIL_CUED);
		r.hot_open = (mode != MODE_UNTIL_HOTKEY);
		r.started = 1'b1;
		r.held = eff_paused(r, m);
		return r;
	endfunction

	// Common entry of the layer commands: title change, mode change, cue gate.
	function automatic chan_t prepare(chan_t s, item_t it, mode_t mode, map_t m);
		chan_t r;
		logic first;
		logic changed;
		r = s;
		first = !s.started;
		changed = it.title_given && !first && s.present && (s.title != it.title_number);
		if (it.title_given) begin
			r.title = it.title_number;
			r.present = 1'b1;
		end
		if (first || changed || (s.mode != mode))
			r = start_mode(r, mode, m);
		if (it.title_given)
			r.cued_last = it.title_cued_flag;
		if (r.mode == MODE_UNTIL_CUED && r.cued_last)
			r.cue_open = 1'b1;
		r.started = 1'b1;
		r.held = eff_paused(r, m);
		return r;
	endfunction

	// Negative requests clamp to zero, large ones to the custom mode.
	function automatic mode_t clamp_mode(logic signed [MODE_BITS-1:0] raw);
		mode_t r;
		if (raw < 0)
			r = MODE_ALWAYS;
		else if (raw > 3)
			r = MODE_CUSTOM;
		else
			r = mode_t'(raw[1:0]);
		return r;
	endfunction

	// Count as seen on the 32-bit result field.
	function automatic logic [OUT_COUNT_BITS-1:0] sat_count(cnt_t c);
		logic [OUT_COUNT_BITS-1:0] r;
		if ((c >> OUT_COUNT_BITS) != '0)
			r = '1;
		else
			r = OUT_COUNT_BITS'(c);
		return r;
	endfunction

endpackage

// ===== src/tpgt_step.sv =====
module tpgt_step (
	input tpgt_pkg::chan_t cur,
	input tpgt_pkg::map_t map_cur,
	input tpgt_pkg::item_t item,
	output tpgt_pkg::chan_t nxt,
	output tpgt_pkg::map_t map_nxt,
	output tpgt_pkg::result_t result
);

	tpgt_pkg::mode_t mode;
	tpgt_pkg::chan_t s;
	tpgt_pkg::map_t m;

	assign mode = tpgt_pkg::clamp_mode(item.mode_request);

	// Apply one command to the channel state and the adaptive map.
	always_comb begin
		s = cur;
		m = map_cur;
		unique case (item.cmd)
			tpgt_pkg::CMD_TICK: begin
				if (s.started && !s.held && (s.cnt != '1))
					s.cnt = s.cnt + tpgt_pkg::cnt_t'(1);
			end
			tpgt_pkg::CMD_SAMPLE: begin
				if (item.is_ticker_layer)
					s = tpgt_pkg::prepare(s, item, mode, m);
			end
			tpgt_pkg::CMD_TOGGLE: begin
				if (item.is_ticker_layer) begin
					s = tpgt_pkg::prepare(s, item, mode, m);
					if (s.mode == tpgt_pkg::MODE_UNTIL_CUED && !s.cue_open) begin
						s.cue_open = 1'b1;
						s.manual = 1'b0;
					end else if (s.mode == tpgt_pkg::MODE_UNTIL_HOTKEY && !s.hot_open) begin
						s.hot_open = 1'b1;
						s.manual = 1'b0;
					end else begin
						s.manual = !s.manual;
					end
					s.held = tpgt_pkg::eff_paused(s, m);
				end
			end
			tpgt_pkg::CMD_STOP: begin
				if (item.is_ticker_layer) begin
					s = tpgt_pkg::prepare(s, item, mode, m);
					s.cnt = '0;
					s.manual = 1'b1;
					if (s.mode == tpgt_pkg::MODE_UNTIL_HOTKEY)
						s.hot_open = 1'b1;
					s.held = 1'b1;
				end
			end
			tpgt_pkg::CMD_MODE_RESET: begin
				if (item.is_ticker_layer) begin
					s.title = item.title_given ? item.title_number : '0;
					s.present = item.title_given;
					s.cued_last = item.title_cued_flag;
					s = tpgt_pkg::start_mode(s, mode, m);
					if (s.mode == tpgt_pkg::MODE_UNTIL_CUED && item.title_cued_flag) begin
						s.cue_open = 1'b1;
						s.held = tpgt_pkg::eff_paused(s, m);
					end
				end
			end
			tpgt_pkg::CMD_ADAPTIVE: begin
				if (item.title_given && tpgt_pkg::title_in_map(item.title_number)
						&& (tpgt_pkg::map_read(m, item.title_number) != item.adaptive_request)) begin
					m[tpgt_pkg::MAP_IW'(item.title_number)] = item.adaptive_request;
					if (s.started && s.present && (s.title == item.title_number))
						s.held = tpgt_pkg::eff_paused(s, m);
				end
			end
			tpgt_pkg::CMD_CLEAR_TITLE: begin
				if (s.started && (item.title_given
						? (s.present && (s.title == item.title_number)) : !s.present))
					s = tpgt_pkg::CHAN_RESET;
				if (item.title_given && tpgt_pkg::title_in_map(item.title_number))
					m[tpgt_pkg::MAP_IW'(item.title_number)] = 1'b0;
			end
			tpgt_pkg::CMD_CLEAR_ALL: begin
				s = tpgt_pkg::CHAN_RESET;
				m = '0;
			end
			default: begin
				s = cur;
			end
		endcase
	end

	assign nxt = s;
	assign map_nxt = m;

	// A layer that is not a ticker reports zeros.
	always_comb begin
		result.paused_now = item.is_ticker_layer ? s.held : 1'b0;
		result.elapsed_count = item.is_ticker_layer ? tpgt_pkg::sat_count(s.cnt) : '0;
	end

endmodule

// ===== src/tpgt_state.sv =====
module tpgt_state (
	input logic clk,
	input logic arst_n,
	input logic en,
	input tpgt_pkg::chan_t nxt,
	input tpgt_pkg::map_t map_nxt,
	output tpgt_pkg::chan_t chan_q,
	output tpgt_pkg::map_t map_q
);

	// Channel state and adaptive map, updated once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= tpgt_pkg::CHAN_RESET;
			map_q <= '0;
		end else if (en) begin
			chan_q <= nxt;
			map_q <= map_nxt;
		end
	end

endmodule

// ===== src/ticker_playback_gate_timer_core.sv =====
// A word accepted into the input register passes through the step logic into the result register.
// One word per cycle while the result word is not stalled; the state register
// is written with the result register, so the next word sees it without a bubble.
// Reset (arst_n low) clears the channel to its idle values, the adaptive map
// to all zero, and drops both valid flags.
`include "assert_macros.svh"

module ticker_playback_gate_timer_core (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [0] is_ticker_layer, [1] title_given, [5:2] title_number,
	// [6] title_cued_flag, [10:7] mode_request, [11] adaptive_request, [15:12] zero
	input logic [15:0] s_axis_tdata,
	// [2:0] cmd
	input logic [2:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [0] paused_now, [32:1] elapsed_count, [39:33] zero
	output logic [39:0] m_axis_tdata
);

	tpgt_pkg::item_t item_in;
	tpgt_pkg::item_t item_s1;
	logic valid_s1;
	logic adv;
	tpgt_pkg::chan_t chan_q;
	tpgt_pkg::chan_t chan_nxt;
	tpgt_pkg::map_t map_q;
	tpgt_pkg::map_t map_nxt;
	tpgt_pkg::result_t result;
	tpgt_pkg::result_t out_q;
	logic out_valid_q;

	// Unpack the incoming word.
	always_comb begin
		item_in.cmd = tpgt_pkg::cmd_t'(s_axis_tuser);
		item_in.is_ticker_layer = s_axis_tdata[0];
		item_in.title_given = s_axis_tdata[1];
		item_in.title_number = s_axis_tdata[5:2];
		item_in.title_cued_flag = s_axis_tdata[6];
		item_in.mode_request = s_axis_tdata[10:7];
		item_in.adaptive_request = s_axis_tdata[11];
	end

	// The registered word moves on unless the result register is stalled.
	assign adv = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	tpgt_step u_step (
		.cur(chan_q),
		.map_cur(map_q),
		.item(item_s1),
		.nxt(chan_nxt),
		.map_nxt(map_nxt),
		.result(result)
	);

	tpgt_state u_state (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.nxt(chan_nxt),
		.map_nxt(map_nxt),
		.chan_q(chan_q),
		.map_q(map_q)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'b0, out_q.elapsed_count, out_q.paused_now};

	// Back-pressure on the input only comes from a stalled result word.
	`ASSERT_PROP(a_ready_low_only_on_stall, clk, arst_n,
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
	// A word from a layer that is not a ticker reports zeros.
	`ASSERT_PROP(a_non_ticker_zero, clk, arst_n,
		(adv && !item_s1.is_ticker_layer) |=> (out_q == '0))
	// The count only holds, steps up by one, or restarts at zero.
	`ASSERT_PROP(a_count_steps, clk, arst_n,
		1'b1 |=> ((chan_q.cnt == $past(chan_q.cnt))
			|| (chan_q.cnt == $past(chan_q.cnt) + tpgt_pkg::cnt_t'(1))
			|| (chan_q.cnt == '0)))

endmodule
